@@ rtl/assert_macros.svh @@
// assertion macros used by the screen writer sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tscw_pkg.sv @@
// package with constants, codes and types of the text screen writer
`timescale 1ns / 1ps
`default_nettype none

package tscw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 24;

   localparam int REQ_TYPE_W  = 1;
   localparam int CHAR_W      = 9;
   localparam int ADDR_W      = 11;
   localparam int CURSOR_W    = 11;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int GLYPH_W     = 8;

   localparam logic [REQ_TYPE_W-1:0] REQ_PUT  = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 9'd10;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 9'h100;
   localparam logic [CHAR_W-1:0] CODE_LEFT      = 9'h0E4;
   localparam logic [CHAR_W-1:0] CODE_RIGHT     = 9'h0E5;

   localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;
   localparam logic [ATTR_W-1:0]  ATTR_RESET  = 8'h07;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_pos;
      logic [CELL_W-1:0]   cell_data;
      logic                scrolled;
   } res_type;

endpackage

`default_nettype wire

@@ rtl/tscw_req_if.sv @@
// request channel: item type, character code and cell address
`timescale 1ns / 1ps
`default_nettype none

interface tscw_req_if;
   import tscw_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CHAR_W-1:0]     char_code;
   logic [ADDR_W-1:0]     cell_addr;

   modport source (output valid, output req_type, output char_code, output cell_addr,
                   input ready);
   modport sink (input valid, input req_type, input char_code, input cell_addr,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/tscw_rsp_if.sv @@
// response channel: cursor position, cell data and scroll flag
`timescale 1ns / 1ps
`default_nettype none

interface tscw_rsp_if;
   import tscw_pkg::*;

   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_pos;
   logic [CELL_W-1:0]   cell_data;
   logic                scrolled;

   modport source (output valid, output cursor_pos, output cell_data, output scrolled,
                   input ready);
   modport sink (input valid, input cursor_pos, input cell_data, input scrolled,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/tscw_screen_ram.sv @@
// screen cell memory: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none

module tscw_screen_ram #(
   parameter int DEPTH = tscw_pkg::COLUMNS_DEF * tscw_pkg::ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(DEPTH)-1:0]       waddr,
   input  logic [tscw_pkg::CELL_W-1:0]    wdata,
   input  logic [$clog2(DEPTH)-1:0]       raddr,
   output logic [tscw_pkg::CELL_W-1:0]    rdata_ff
);
   import tscw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

@@ rtl/tscw_seq.sv @@
// sequencer: cursor update, cell writes, scroll copy and clearing sweeps
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tscw_seq #(
   parameter int COLUMNS = tscw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tscw_pkg::ROWS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tscw_req_if.sink                              req,
   input  logic [tscw_pkg::ATTR_W-1:0]           attr,
   output logic                                  mem_we,
   output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_waddr,
   output logic [tscw_pkg::CELL_W-1:0]           mem_wdata,
   output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_raddr,
   input  logic [tscw_pkg::CELL_W-1:0]           mem_rdata,
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output tscw_pkg::res_type                     res
);
   import tscw_pkg::*;

   localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int CW = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_ROW_START = AW'(CELL_COUNT - COLUMNS);
   localparam logic [AW-1:0] LAST_CELL      = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] COLUMNS_A      = AW'(COLUMNS);
   localparam logic [CW-1:0] COL_MAX        = CW'(COLUMNS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_COPY  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] data_ff, data_in;
   logic              scrolled_ff, scrolled_in;

   logic acc;
   logic last_row;
   logic at_zero;
   logic wrap;
   logic scroll;

   assign req.ready = (state_ff == ST_IDLE);
   assign acc       = req.valid && req.ready;
   assign last_row  = (pos_ff >= LAST_ROW_START);
   assign at_zero   = (pos_ff == '0);
   assign wrap      = (col_ff == COL_MAX);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      col_in      = col_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      wr_addr_in  = cnt_ff;
      data_in     = data_ff;
      scrolled_in = scrolled_ff;
      scroll      = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = pos_ff;
      mem_wdata   = '0;
      mem_raddr   = AW'(req.cell_addr);

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            if (cnt_ff == LAST_CELL) begin
               // the power-up sweep ends idle, the last-row clear ends with a result
               state_in = scrolled_ff ? ST_DONE : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               data_in     = '0;
               scrolled_in = 1'b0;
               if (req.req_type == REQ_READ) begin
                  if (32'(req.cell_addr) < CELL_COUNT) begin
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  case (req.char_code)
                     CODE_NEWLINE: begin
                        col_in = '0;
                        if (last_row) begin
                           scroll = 1'b1;
                        end else begin
                           pos_in = pos_ff - AW'(col_ff) + COLUMNS_A;
                        end
                     end
                     CODE_BACKSPACE, CODE_LEFT: begin
                        if (!at_zero) begin
                           pos_in = pos_ff - 1'b1;
                           col_in = (col_ff == '0) ? COL_MAX : col_ff - 1'b1;
                           if (req.char_code == CODE_BACKSPACE) begin
                              mem_we    = 1'b1;
                              mem_waddr = pos_ff - 1'b1;
                              mem_wdata = {attr, GLYPH_SPACE};
                           end
                        end
                     end
                     default: begin
                        // right arrow and glyphs advance; glyphs also store a cell
                        if (req.char_code != CODE_RIGHT) begin
                           mem_we    = 1'b1;
                           mem_waddr = pos_ff;
                           mem_wdata = {attr, req.char_code[GLYPH_W-1:0]};
                        end
                        if (wrap) begin
                           col_in = '0;
                           if (last_row) begin
                              scroll = 1'b1;
                           end else begin
                              pos_in = pos_ff + 1'b1;
                           end
                        end else begin
                           pos_in = pos_ff + 1'b1;
                           col_in = col_ff + 1'b1;
                        end
                     end
                  endcase
                  if (scroll) begin
                     pos_in      = LAST_ROW_START;
                     col_in      = '0;
                     scrolled_in = 1'b1;
                     cnt_in      = '0;
                     state_in    = ST_COPY;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_READ: begin
            data_in  = mem_rdata;
            state_in = ST_DONE;
         end
         ST_COPY: begin
            // read one row below, write the cell read in the previous cycle
            mem_raddr = cnt_ff + COLUMNS_A;
            mem_we    = pend_ff;
            mem_waddr = wr_addr_ff;
            mem_wdata = mem_rdata;
            if (cnt_ff == LAST_ROW_START) begin
               state_in = ST_CLEAR;
            end else begin
               pend_in    = 1'b1;
               wr_addr_in = cnt_ff;
               cnt_in     = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         pos_ff      <= '0;
         col_ff      <= '0;
         cnt_ff      <= '0;
         pend_ff     <= 1'b0;
         scrolled_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         col_ff      <= col_in;
         cnt_ff      <= cnt_in;
         pend_ff     <= pend_in;
         scrolled_ff <= scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      data_ff    <= data_in;
   end

   assign res_valid      = (state_ff == ST_DONE);
   assign res.cursor_pos = CURSOR_W'(pos_ff);
   assign res.cell_data  = data_ff;
   assign res.scrolled   = scrolled_ff;

   `ASSERT_ALWAYS(a_cursor_range, clock, reset, {1'b0, pos_ff} < (AW+1)'(CELL_COUNT), "cursor out of screen")
   `ASSERT_ALWAYS(a_col_range, clock, reset, 32'(col_ff) < COLUMNS, "cursor column out of row")
   `ASSERT_IMPLY(a_copy_cursor, clock, reset, state_ff == ST_COPY, pos_ff == LAST_ROW_START && scrolled_ff, "cursor not parked during scroll")
   `ASSERT_IMPLY(a_done_quiet, clock, reset, state_ff == ST_DONE || state_ff == ST_READ, !mem_we, "cell write while a result is pending")
   `ASSERT_NEXT(a_done_stays, clock, reset, res_valid && !res_ready, res_valid && $stable(res), "result dropped before transfer")

endmodule

`default_nettype wire

@@ rtl/text_screen_cursor_engine.sv @@
// top level of the text screen writer: attribute register, cell memory, sequencer, result register
`timescale 1ns / 1ps
`default_nettype none

// Text screen writer owning a COLUMNS x ROWS memory of 16-bit cells (attribute in the
// upper byte, glyph in the lower byte) and a cursor. After reset the block sweeps all
// COLUMNS*ROWS cells (1920 by default) to zero, one cell a cycle, before it takes its
// first item; csr writes of the attribute are taken at any time. A put without scroll
// goes from idle straight to the result state, and so does a read of an address off
// the screen; a read of a cell on the screen first passes a read state that waits for
// the registered read of the memory. A put that scrolls moves the screen up one cell a
// cycle and then clears the last row. One item is in work at a time; the result sits
// in an output register, so the next item may be taken while the previous result
// waits for its transfer.
module text_screen_cursor_engine #(
   parameter int COLUMNS = tscw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tscw_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   tscw_req_if.sink                      req_ch,
   tscw_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [tscw_pkg::ATTR_W-1:0]   csr_wdata
);
   import tscw_pkg::*;

   localparam int AW = $clog2(COLUMNS * ROWS);

   logic [ATTR_W-1:0] attr_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [CELL_W-1:0] mem_rdata;
   logic              res_valid;
   logic              res_ready;
   res_type           res;
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_we) begin
         attr_ff <= csr_wdata;
      end
   end

   tscw_screen_ram #(
      .DEPTH (COLUMNS * ROWS)
   ) u_ram (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (mem_waddr),
      .wdata    (mem_wdata),
      .raddr    (mem_raddr),
      .rdata_ff (mem_rdata)
   );

   tscw_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .attr      (attr_ff),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register frees the sequencer as soon as the result is parked
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cursor_pos = rsp_ff.cursor_pos;
   assign rsp_ch.cell_data  = rsp_ff.cell_data;
   assign rsp_ch.scrolled   = rsp_ff.scrolled;

endmodule

`default_nettype wire

@@ bench/text_screen_cursor_engine_test.sv @@
// self-checking testbench of the text screen writer: cursor moves, cell writes, scrolls, reads
`timescale 1ns / 1ps

module text_screen_cursor_engine_test;
   import tscw_pkg::*;

   localparam int COLUMNS   = COLUMNS_DEF;
   localparam int ROWS      = ROWS_DEF;
   localparam int CELLS     = COLUMNS * ROWS;
   localparam int ADDR_TOP  = (1 << ADDR_W) - 1;
   localparam int CODE_TOP  = (1 << CHAR_W) - 1;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [CHAR_W-1:0]     char_code;
      logic [ADDR_W-1:0]     cell_addr;
   } screen_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [ATTR_W-1:0] csr_wdata;

   tscw_req_if req_ch ();
   tscw_rsp_if rsp_ch ();

   text_screen_cursor_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // screen image and cursor as the block should hold them
   logic [CELL_W-1:0]   screen_image [0:CELLS-1];
   logic [CURSOR_W-1:0] cursor_image;
   logic [ATTR_W-1:0]   attr_image;

   screen_item_type pending_items [$];
   res_type         screen_results [$];
   screen_item_type drive_item;
   res_type         want_result;

   int queued_count   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int fail_count     = 0;
   int scroll_count   = 0;
   int attr_settings  = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   int hold_request   = 0;
   int hold_seen      = 0;
   logic no_idle      = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one accepted item to the screen image and queue the result it causes
   task automatic apply_screen_item(input screen_item_type it);
      res_type exp_res;
      int pos;
      exp_res = '0;
      pos = int'(cursor_image);
      if (pos >= CELLS) pos = 0;
      if (it.req_type == REQ_READ) begin
         if (it.cell_addr < CELLS) exp_res.cell_data = screen_image[it.cell_addr];
      end else begin
         if (it.char_code == CODE_NEWLINE) begin
            pos = pos + COLUMNS - pos % COLUMNS;
         end else if (it.char_code == CODE_BACKSPACE) begin
            if (pos > 0) begin
               pos = pos - 1;
               screen_image[pos] = {attr_image, GLYPH_SPACE};
            end
         end else if (it.char_code == CODE_LEFT) begin
            if (pos > 0) pos = pos - 1;
         end else if (it.char_code == CODE_RIGHT) begin
            pos = pos + 1;
         end else begin
            screen_image[pos] = {attr_image, it.char_code[GLYPH_W-1:0]};
            pos = pos + 1;
         end
         cursor_image = CURSOR_W'(pos);
         if (pos >= CELLS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen_image[i] = screen_image[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_image[i] = '0;
            cursor_image = CURSOR_W'(CELLS - COLUMNS);
            exp_res.scrolled = 1'b1;
            scroll_count++;
         end
      end
      exp_res.cursor_pos = cursor_image;
      screen_results.push_back(exp_res);
   endtask

   task automatic push_item(input logic [REQ_TYPE_W-1:0] kind, input int code, input int addr);
      screen_item_type it;
      it.req_type  = kind;
      it.char_code = CHAR_W'(code);
      it.cell_addr = ADDR_W'(addr);
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic push_random_items(input int count);
      int r;
      int code;
      int addr;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 22) begin
            case ($urandom_range(0, 9))
               0: addr = $urandom_range(CELLS, ADDR_TOP);
               1, 2, 3: addr = $urandom_range(CELLS - COLUMNS, CELLS - 1);
               default: addr = $urandom_range(0, CELLS - 1);
            endcase
            push_item(REQ_READ, $urandom_range(0, CODE_TOP), addr);
         end else begin
            if (r < 30) code = CODE_NEWLINE;
            else if (r < 35) code = CODE_BACKSPACE;
            else if (r < 40) code = CODE_LEFT;
            else if (r < 45) code = CODE_RIGHT;
            else code = $urandom_range(0, CODE_TOP);
            push_item(REQ_PUT, code, $urandom_range(0, ADDR_TOP));
         end
      end
   endtask

   task automatic wait_drained;
      while (checked_count != queued_count) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      attr_image = value;
      attr_settings++;
   endtask

   // request driver: random gaps between transfers, prediction on every accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_screen_item(drive_item);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
               req_ch.valid <= 1'b0;
               gap_left     <= gap_left - 1;
            end else if (pending_items.size() != 0 && !no_idle && $urandom_range(0, 99) < 6) begin
               req_ch.valid <= 1'b0;
               gap_left     <= $urandom_range(1, 19) - 1;
            end else if (pending_items.size() != 0) begin
               drive_item          = pending_items.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.req_type    <= drive_item.req_type;
               req_ch.char_code   <= drive_item.char_code;
               req_ch.cell_addr   <= drive_item.cell_addr;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response ready: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
         hold_left    <= 0;
      end else if (hold_request != hold_seen) begin
         hold_seen    <= hold_request;
         hold_left    <= LONG_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 8) begin
         stall_left   <= $urandom_range(1, 19) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (screen_results.size() == 0) begin
            $error("response transfer with no item outstanding");
            fail_count++;
         end else begin
            want_result = screen_results.pop_front();
            if (rsp_ch.cursor_pos !== want_result.cursor_pos) begin
               $error("cursor_pos expected %0d actual %0d", want_result.cursor_pos,
                      rsp_ch.cursor_pos);
               fail_count++;
            end
            if (rsp_ch.cell_data !== want_result.cell_data) begin
               $error("cell_data expected 0x%04h actual 0x%04h", want_result.cell_data,
                      rsp_ch.cell_data);
               fail_count++;
            end
            if (rsp_ch.scrolled !== want_result.scrolled) begin
               $error("scrolled expected %0d actual %0d", want_result.scrolled,
                      rsp_ch.scrolled);
               fail_count++;
            end
            checked_count++;
         end
      end
   end

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_PUT;
      req_ch.char_code = '0;
      req_ch.cell_addr = '0;
      rsp_ch.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      for (int i = 0; i < CELLS; i++) screen_image[i] = '0;
      cursor_image = '0;
      attr_image   = ATTR_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part with the reset attribute
      push_item(REQ_READ, 0, 0);
      push_item(REQ_READ, 0, CELLS - 1);
      push_item(REQ_READ, CODE_TOP, CELLS);
      push_item(REQ_READ, CODE_TOP, ADDR_TOP);
      push_item(REQ_PUT, CODE_BACKSPACE, 0);    // backspace at home does nothing
      push_item(REQ_PUT, CODE_LEFT, 0);         // left arrow pinned at home
      push_item(REQ_PUT, 'h041, 0);
      push_item(REQ_PUT, 'h000, 0);
      push_item(REQ_PUT, 'h0FF, 0);
      push_item(REQ_PUT, 'h1FF, 0);             // codes above a byte keep the low byte
      push_item(REQ_PUT, 'h1E4, 0);
      push_item(REQ_PUT, 'h10A, 0);
      push_item(REQ_PUT, CODE_RIGHT, 0);
      push_item(REQ_PUT, CODE_LEFT, 0);
      push_item(REQ_PUT, CODE_BACKSPACE, 0);    // blanks with a space
      push_item(REQ_PUT, CODE_NEWLINE, 0);
      push_item(REQ_PUT, 'h0AA, ADDR_TOP);
      push_item(REQ_READ, 0, 0);
      push_item(REQ_READ, 0, 3);
      push_item(REQ_READ, 0, 4);
      push_item(REQ_READ, 0, 5);
      push_item(REQ_READ, 0, 7);
      push_item(REQ_READ, 0, COLUMNS);
      wait_drained();

      write_attribute('0);
      push_random_items(150);
      @(posedge clock);
      hold_request <= hold_request + 1;         // fill the block while responses are held
      wait_drained();

      write_attribute('1);
      push_random_items(150);
      wait_drained();

      write_attribute(ATTR_W'($urandom_range(1, 254)));
      push_random_items(200);
      wait_drained();

      write_attribute(ATTR_W'($urandom_range(0, 255)));
      push_random_items(200);
      wait_drained();

      write_attribute(ATTR_W'($urandom_range(0, 255)));
      no_idle <= 1'b1;
      push_random_items(200);
      wait_drained();

      repeat (20) @(posedge clock);
      $display("run covered %0d item transfers, %0d responses checked, %0d scrolls",
               accepted_count, checked_count, scroll_count);
      $display("attribute register written %0d times including both extremes", attr_settings);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d responses outstanding", queued_count - checked_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
